// ===== rtl/core/frkc_pkg.sv =====
`timescale 1ns / 1ps

package frkc_pkg;

  // request codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  // fixed field and table geometry
  localparam int TABLE_ENTRIES = 13;
  localparam int IDX_W         = 4;
  localparam int FREQ_W        = 24;
  localparam int FRAC_W        = 12;
  localparam int RATIO_W       = 32;
  localparam int ENTRY_W       = 16;
  localparam int KEY_W         = 8;
  localparam int CENTS_W       = 7;
  localparam int SEMIS_PER_OCT = 12;
  localparam int CENTS_FULL    = 100;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_DIV_END,
    S_NORM,
    S_LO_RD,
    S_LO_CMP,
    S_HI_RD,
    S_HI_CMP,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/freq_ratio_to_key_cents.sv =====
`timescale 1ns / 1ps

// Frequency ratio to note key and fine tune.
// Input channel: in_valid / in_stall carry one request. A load request
// (req_type 0) writes table_value into ratio table entry table_index when
// that index is below TABLE_ENTRIES and gives no result. A convert request
// gives one result on the output channel out_valid / out_stall: note_key,
// fine_cents, div_error. The block works on one request at a time and holds
// in_stall high while busy. A convert skips the divider when the frequencies
// are equal or a divisor is zero; otherwise it uses one shared restoring
// divider that retires one quotient bit per cycle. It runs 36 steps for the
// 24.12 ratio, then 28 steps for the fine tune unless the next entry is not
// above the chosen one. Between the passes come up to MAX_OCTAVES single-bit
// normalize shifts and a descending table search, one read and one compare
// per entry, on the table's single read port. The next request is taken in
// the cycle after a result moves into the output register.
// Reset clears the sequencer and the output valid; the ratio table is not
// cleared and every entry must be loaded before a convert reads it.
// A result waits in the output register while out_stall is high; a later
// convert result holds in the sequencer until that register has been freed.
module freq_ratio_to_key_cents import frkc_pkg::*; #(
  parameter int MAX_OCTAVES = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [IDX_W-1:0]   table_index,
  input  logic [ENTRY_W-1:0] table_value,
  input  logic [FREQ_W-1:0]  target_freq,
  input  logic [FREQ_W-1:0]  base_freq,
  input  logic [KEY_W-1:0]   base_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KEY_W-1:0]   note_key,
  output logic [CENTS_W-1:0] fine_cents,
  output logic               div_error
);

  localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
  localparam int F_W     = RATIO_W - MAX_OCTAVES;
  localparam int PROD_W  = F_W + CENTS_W;
  localparam int RDIV_W  = FREQ_W + FRAC_W;
  localparam int DIV_W   = (PROD_W > RDIV_W) ? PROD_W : RDIV_W;
  localparam int CNT_W   = $clog2(DIV_W + 1);
  localparam int PAD_W   = DIV_W - PROD_W;

  state_t state, state_next;

  // ratio table memory
  logic [ENTRY_W-1:0] ratio_table [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;

  // divider registers
  logic [DIV_W-1:0]   quo;
  logic [FREQ_W-1:0]  rem;
  logic [FREQ_W-1:0]  den;
  logic [CNT_W-1:0]   cnt;
  logic               pass;

  // working registers
  logic [RATIO_W-1:0] f;
  logic [OCT_W-1:0]   oct;
  logic [IDX_W-1:0]   semi;
  logic [ENTRY_W-1:0] lo;
  logic [CENTS_W-1:0] cents;
  logic [KEY_W-1:0]   bkey;
  logic               up;
  logic               eq;
  logic               err;

  logic               accept;
  logic               out_ld;
  logic               freq_eq;
  logic               freq_up;
  logic               zero_den;

  // divider step
  logic [FREQ_W:0]    div_sh;
  logic [FREQ_W:0]    div_trial;
  logic               div_ge;

  // interpolation terms
  logic               f_above_lo;
  logic [F_W-1:0]     diff;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  cents_q;

  // key terms
  logic [KEY_W-1:0]   steps;
  logic               normalize_more;
  logic               search_more;

  assign accept  = in_valid && !in_stall;
  assign freq_eq = (target_freq == base_freq);
  assign freq_up = (base_freq < target_freq);
  assign zero_den = freq_up ? (base_freq == '0) : (target_freq == '0);

  assign div_sh    = {rem, quo[DIV_W-1]};
  assign div_ge    = (div_sh >= {1'b0, den});
  assign div_trial = div_sh - {1'b0, den};

  assign normalize_more = (oct < OCT_W'(MAX_OCTAVES)) && (f[RATIO_W-1:FRAC_W+1] != '0);
  assign search_more    = (semi != '0) && !(f > RATIO_W'(rd_data));

  assign f_above_lo = (f > RATIO_W'(lo));
  assign diff       = f_above_lo ? (f[F_W-1:0] - F_W'(lo)) : '0;
  assign prod       = PROD_W'(diff) * PROD_W'(CENTS_FULL);
  assign cents_q    = quo[PROD_W-1:0];

  assign steps = KEY_W'(oct) * KEY_W'(SEMIS_PER_OCT) + KEY_W'(semi);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_CONVERT) begin
          if (freq_eq || zero_den) state_next = S_DONE;
          else                     state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == CNT_W'(1)) state_next = S_DIV_END;
      end
      S_DIV_END: begin
        if (pass) state_next = S_DONE;
        else      state_next = S_NORM;
      end
      S_NORM: begin
        if (!normalize_more) state_next = S_LO_RD;
      end
      S_LO_RD:  state_next = S_LO_CMP;
      S_LO_CMP: begin
        if (search_more) state_next = S_LO_RD;
        else             state_next = S_HI_RD;
      end
      S_HI_RD:  state_next = S_HI_CMP;
      S_HI_CMP: begin
        if (rd_data <= lo) state_next = S_DONE;
        else               state_next = S_DIV;
      end
      S_DONE: begin
        if (out_ld) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state != S_IDLE);
    out_ld   = (state == S_DONE) && (!out_valid || !out_stall);
    rd_addr  = (state == S_HI_RD) ? (semi + IDX_W'(1)) : semi;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // table write on load, registered read
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_LOAD && table_index < IDX_W'(TABLE_ENTRIES)) begin
      ratio_table[table_index] <= table_value;
    end
    rd_data <= ratio_table[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        bkey <= base_key;
        up   <= freq_up;
        eq   <= freq_eq;
        err  <= !freq_eq && zero_den;
        oct  <= '0;
        pass <= 1'b0;
        rem  <= '0;
        cnt  <= CNT_W'(DIV_W);
        den  <= freq_up ? base_freq : target_freq;
        quo  <= DIV_W'({(freq_up ? target_freq : base_freq), {FRAC_W{1'b0}}});
      end
      S_DIV: begin
        rem <= div_ge ? div_trial[FREQ_W-1:0] : div_sh[FREQ_W-1:0];
        quo <= {quo[DIV_W-2:0], div_ge};
        cnt <= cnt - CNT_W'(1);
      end
      S_DIV_END: begin
        if (pass) begin
          cents <= (cents_q > PROD_W'(CENTS_FULL)) ? CENTS_W'(CENTS_FULL)
                                                   : cents_q[CENTS_W-1:0];
        end else if (quo[DIV_W-1:RATIO_W] != '0) begin
          f <= '1;
        end else begin
          f <= quo[RATIO_W-1:0];
        end
      end
      S_NORM: begin
        if (normalize_more) begin
          f   <= f >> 1;
          oct <= oct + OCT_W'(1);
        end else begin
          semi <= IDX_W'(TABLE_ENTRIES - 2);
        end
      end
      S_LO_CMP: begin
        if (search_more) semi <= semi - IDX_W'(1);
        else             lo   <= rd_data;
      end
      S_HI_CMP: begin
        cents <= '0;
        pass  <= 1'b1;
        rem   <= '0;
        den   <= FREQ_W'(rd_data - lo);
        cnt   <= CNT_W'(PROD_W);
        quo   <= DIV_W'(prod) << PAD_W;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      div_error <= err;
      if (err) begin
        note_key   <= '0;
        fine_cents <= '0;
      end else if (eq) begin
        note_key   <= bkey;
        fine_cents <= '0;
      end else if (up) begin
        note_key   <= bkey + steps;
        fine_cents <= cents;
      end else if (steps <= bkey) begin
        note_key   <= bkey - steps;
        fine_cents <= cents;
      end else begin
        note_key   <= '0;
        fine_cents <= '0;
      end
    end
  end

endmodule

// ===== verif/freq_ratio_to_key_cents_test.sv =====
`timescale 1ns / 1ps

module freq_ratio_to_key_cents_test;
  import frkc_pkg::*;

  localparam int MAX_OCTAVES     = 11;
  localparam int MISMATCH_SHOWN  = 10;
  localparam int RANDOM_REQUESTS = 1422;
  localparam int DRAIN_CYCLES    = 150;
  localparam int IDLE_PERCENT    = 28;

  // one expected convert outcome
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CENTS_W-1:0] cents;
    logic               err;
  } tuning_t;

  // tracks the ratio table and the tunings still owed by the block
  class pitch_checker;
    logic [ENTRY_W-1:0] ratio_tbl [TABLE_ENTRIES];
    tuning_t            due_tunings [$];
    int                 mismatches;

    function new();
      mismatches = 0;
      foreach (ratio_tbl[k]) ratio_tbl[k] = '0;
    endfunction

    // larger over smaller in 20.12, saturating at 32 bits
    function logic [RATIO_W-1:0] ratio_q12(logic [FREQ_W-1:0] num, logic [FREQ_W-1:0] den);
      logic [63:0] q;
      q = (64'(num) << FRAC_W) / 64'(den);
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      return q[RATIO_W-1:0];
    endfunction

    // octave count, semitone entry and interpolated cents of a 20.12 ratio
    function void split_ratio(input logic [RATIO_W-1:0] ratio, output int unsigned oct,
                              output int unsigned semi, output int unsigned cents);
      logic [RATIO_W-1:0] f;
      logic [63:0]        frac;
      logic [63:0]        span;
      oct = 0;
      while (oct < MAX_OCTAVES && (ratio >> FRAC_W) >= (32'd1 << (oct + 1))) oct++;
      f = ratio >> oct;
      // descending search, stops at entry 0
      semi = TABLE_ENTRIES - 2;
      while (semi > 0 && f <= ratio_tbl[semi]) semi--;
      if (ratio_tbl[semi + 1] <= ratio_tbl[semi]) begin
        cents = 0;
      end else begin
        frac = (f > ratio_tbl[semi]) ? 64'(f - ratio_tbl[semi]) : 64'd0;
        span = 64'(ratio_tbl[semi + 1]) - 64'(ratio_tbl[semi]);
        frac = frac * CENTS_FULL / span;
        cents = (frac > CENTS_FULL) ? CENTS_FULL : frac[31:0];
      end
    endfunction

    function tuning_t tune_from_ratio(logic [FREQ_W-1:0] tgt, logic [FREQ_W-1:0] base,
                                      logic [KEY_W-1:0] bkey);
      tuning_t     t;
      int unsigned oct;
      int unsigned semi;
      int unsigned cents;
      int unsigned steps;
      t = '0;
      if (tgt == base) begin
        t.key = bkey;
      end else if (base < tgt) begin
        // upward ratio adds to the base key, wrapping
        if (base == 0) begin
          t.err = 1'b1;
        end else begin
          split_ratio(ratio_q12(tgt, base), oct, semi, cents);
          steps = oct * SEMIS_PER_OCT + semi;
          t.key = bkey + steps[KEY_W-1:0];
          t.cents = cents[CENTS_W-1:0];
        end
      end else begin
        // downward ratio subtracts, floor at zero
        if (tgt == 0) begin
          t.err = 1'b1;
        end else begin
          split_ratio(ratio_q12(base, tgt), oct, semi, cents);
          steps = oct * SEMIS_PER_OCT + semi;
          if (steps <= bkey) begin
            t.key = bkey - steps[KEY_W-1:0];
            t.cents = cents[CENTS_W-1:0];
          end
        end
      end
      return t;
    endfunction

    function void note_request(logic rtype, logic [IDX_W-1:0] idx, logic [ENTRY_W-1:0] val,
                               logic [FREQ_W-1:0] tgt, logic [FREQ_W-1:0] base,
                               logic [KEY_W-1:0] bkey);
      if (rtype == REQ_LOAD) begin
        if (idx < TABLE_ENTRIES) ratio_tbl[idx] = val;
      end else begin
        due_tunings.push_back(tune_from_ratio(tgt, base, bkey));
      end
    endfunction

    function void check_result(logic [KEY_W-1:0] key, logic [CENTS_W-1:0] cents, logic err);
      tuning_t want;
      if (due_tunings.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
          $display("result with no request pending: key %0d cents %0d err %0d",
                   key, cents, err);
      end else begin
        want = due_tunings.pop_front();
        if (key !== want.key || cents !== want.cents || err !== want.err) begin
          mismatches++;
          if (mismatches <= MISMATCH_SHOWN)
            $display("mismatch: expected key %0d cents %0d err %0d, got key %0d cents %0d err %0d",
                     want.key, want.cents, want.err, key, cents, err);
        end
      end
    endfunction

    function int pending();
      return due_tunings.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [IDX_W-1:0]   table_index;
  logic [ENTRY_W-1:0] table_value;
  logic [FREQ_W-1:0]  target_freq;
  logic [FREQ_W-1:0]  base_freq;
  logic [KEY_W-1:0]   base_key;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KEY_W-1:0]   note_key;
  logic [CENTS_W-1:0] fine_cents;
  logic               div_error;

  logic         idle_on = 1'b1;
  pitch_checker book = new();

  freq_ratio_to_key_cents #(
    .MAX_OCTAVES(MAX_OCTAVES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .table_index(table_index),
    .table_value(table_value),
    .target_freq(target_freq),
    .base_freq(base_freq),
    .base_key(base_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .note_key(note_key),
    .fine_cents(fine_cents),
    .div_error(div_error)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // semitone ratios of equal temperament in 4.12
  function automatic logic [ENTRY_W-1:0] equal_tempered(int k);
    case (k)
      0:       return 16'd4096;
      1:       return 16'd4340;
      2:       return 16'd4598;
      3:       return 16'd4871;
      4:       return 16'd5161;
      5:       return 16'd5468;
      6:       return 16'd5793;
      7:       return 16'd6137;
      8:       return 16'd6502;
      9:       return 16'd6889;
      10:      return 16'd7298;
      11:      return 16'd7732;
      default: return 16'd8192;
    endcase
  endfunction

  // present one request and hold it until the block takes it
  task automatic send_request(input logic rtype, input logic [IDX_W-1:0] idx,
                              input logic [ENTRY_W-1:0] val, input logic [FREQ_W-1:0] tgt,
                              input logic [FREQ_W-1:0] base, input logic [KEY_W-1:0] bkey);
    while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = rtype;
    table_index = idx;
    table_value = val;
    target_freq = tgt;
    base_freq = base;
    base_key = bkey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_request(rtype, idx, val, tgt, base, bkey);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [IDX_W-1:0] idx, input logic [ENTRY_W-1:0] val);
    send_request(REQ_LOAD, idx, val, FREQ_W'($urandom), FREQ_W'($urandom), KEY_W'($urandom));
  endtask

  task automatic send_convert(input logic [FREQ_W-1:0] tgt, input logic [FREQ_W-1:0] base,
                              input logic [KEY_W-1:0] bkey);
    send_request(REQ_CONVERT, IDX_W'($urandom), ENTRY_W'($urandom), tgt, base, bkey);
  endtask

  // output side stalls at random
  always @(negedge clk) begin
    out_stall = idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // every accepted result is checked against the oldest pending tuning
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) book.check_result(note_key, fine_cents, div_error);
  end

  initial begin
    int unsigned        kind;
    int unsigned        oct;
    int unsigned        r;
    logic [FREQ_W-1:0]  lo_f;
    logic [FREQ_W-1:0]  hi_f;
    logic [63:0]        prod;
    logic [KEY_W-1:0]   bkey;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] val;

    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_LOAD;
    table_index = '0;
    table_value = '0;
    target_freq = '0;
    base_freq = '0;
    base_key = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the whole table, then one out-of-range load that must be ignored
    for (int k = 0; k < TABLE_ENTRIES; k++) send_load(IDX_W'(k), equal_tempered(k));
    send_load(4'd13, 16'hFFFF);

    // equal, zero-divisor and extreme-ratio requests
    send_convert(24'd0, 24'd0, 8'd77);
    send_convert(24'hFFFFFF, 24'hFFFFFF, 8'd0);
    send_convert(24'd0, 24'd12345, 8'd40);
    send_convert(24'hFFFFFF, 24'd0, 8'd40);
    send_convert(24'hFFFFFF, 24'd1, 8'd3);
    send_convert(24'd1, 24'hFFFFFF, 8'd200);
    send_convert(24'd1000001, 24'd1000000, 8'd255);
    send_convert(24'd3000000, 24'd1000000, 8'd250);
    send_convert(24'd1000000, 24'd4000000, 8'd10);

    // top entry not above its neighbor, then close enough that cents saturate
    send_load(4'd12, 16'd7700);
    send_convert(24'd1990000, 24'd1000000, 8'd60);
    send_load(4'd12, 16'd7800);
    send_convert(24'd1990000, 24'd1000000, 8'd60);
    send_load(4'd12, equal_tempered(12));

    // random requests, with a long stretch without idling on either side
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      idle_on = !(n >= 500 && n < 800);
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       bkey = KEY_W'($urandom_range(0, 15));
        1:       bkey = KEY_W'($urandom_range(240, 255));
        default: bkey = KEY_W'($urandom);
      endcase
      if (kind < 8) begin
        // table rewrite, mostly near equal temperament
        idx = IDX_W'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: val = (idx < TABLE_ENTRIES) ? equal_tempered(int'(idx)) : 16'($urandom);
          4, 5, 6:    val = (idx < TABLE_ENTRIES) ?
                            ENTRY_W'(equal_tempered(int'(idx)) + $urandom_range(0, 400) - 200)
                            : 16'($urandom);
          7, 8:       val = ENTRY_W'($urandom);
          default:    val = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        send_load(idx, val);
      end else begin
        if (kind < 16) begin
          lo_f = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom);
          hi_f = lo_f;
        end else if (kind < 21) begin
          lo_f = 24'd0;
          hi_f = FREQ_W'($urandom_range(1, 24'hFFFFFF));
        end else if (kind < 33) begin
          lo_f = FREQ_W'($urandom);
          hi_f = FREQ_W'($urandom);
        end else if (kind < 43) begin
          lo_f = FREQ_W'($urandom_range(1, 255));
          hi_f = FREQ_W'($urandom);
        end else begin
          // ratio built from a chosen octave and semitone region
          oct = $urandom_range(0, MAX_OCTAVES);
          if ($urandom_range(0, 2) == 0)
            r = equal_tempered($urandom_range(0, 12)) + $urandom_range(0, 4) - 2;
          else
            r = $urandom_range(4096, 8191);
          lo_f = FREQ_W'($urandom_range(1, 24'hFFFFFF >> (oct + 1)));
          prod = ((64'(lo_f) * r) << oct) >> FRAC_W;
          hi_f = prod[FREQ_W-1:0];
        end
        if ($urandom_range(0, 1)) send_convert(hi_f, lo_f, bkey);
        else send_convert(lo_f, hi_f, bkey);
      end
    end

    // drain
    in_valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
